// ----- rtl/assert_macros.svh -----
// Assertion macros for the motor command sequencer RTL.
// Clocked concurrent checks with and without the reset qualifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property while out of reset.
`define MCS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every edge, reset cycles included.
`define MCS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/mcs_pkg.sv -----
// Shared types, register codes and driver constants for the motor command sequencer.
// No dependencies.
`default_nettype none

package mcs_pkg;

    localparam int unsigned MAX_WRITES = 4;

    localparam logic [15:0] ADDR_SPEED   = 16'd14;
    localparam logic [15:0] ADDR_CONTROL = 16'd2;
    localparam logic [15:0] WORD_DISABLE = 16'd256;
    localparam logic [15:0] WORD_CW      = 16'd257;
    localparam logic [15:0] WORD_CCW     = 16'd265;

    localparam logic REQ_COMMAND = 1'b0;
    localparam logic REQ_TICK    = 1'b1;

    localparam logic [7:0]  RST_DEADZONE  = 8'd5;
    localparam logic [7:0]  RST_SETTLE_MS = 8'd20;
    localparam logic [15:0] RST_WDOG_MS   = 16'd1000;
    localparam logic        RST_LEFT_INV  = 1'b1;
    localparam logic        RST_RIGHT_INV = 1'b0;
    localparam logic [7:0]  RST_LEFT_ID   = 8'd7;
    localparam logic [7:0]  RST_RIGHT_ID  = 8'd2;

    typedef enum logic [2:0] {
        REG_DEADZONE  = 3'd0,
        REG_SETTLE_MS = 3'd1,
        REG_WDOG_MS   = 3'd2,
        REG_LEFT_INV  = 3'd3,
        REG_RIGHT_INV = 3'd4,
        REG_LEFT_ID   = 3'd5,
        REG_RIGHT_ID  = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        PH_IDLE         = 2'd0,
        PH_WAIT_DISABLE = 2'd1,
        PH_WAIT_SPEED   = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0]  deadzone;
        logic [7:0]  settle_ms;
        logic [15:0] wdog_ms;
        logic        left_inv;
        logic        right_inv;
        logic [7:0]  left_id;
        logic [7:0]  right_id;
    } t_cfg;

    typedef struct packed {
        logic        side;
        logic [15:0] addr;
        logic [15:0] data;
    } t_wr;

    typedef struct packed {
        t_wr [MAX_WRITES-1:0] slot;
        logic [2:0]           cnt;
    } t_batch;

    function automatic logic [8:0] mag9(input logic [8:0] v);
        logic [8:0] res;
        res = v[8] ? (~v + 9'd1) : v;
        return res;
    endfunction

    function automatic logic [15:0] dir_word(input logic neg, input logic inv);
        logic fwd;
        fwd = ~neg ^ inv;
        return fwd ? WORD_CW : WORD_CCW;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/mcs_cfg_regs.sv -----
// APB-style configuration register file of the motor command sequencer.
// Depends on mcs_pkg.
`default_nettype none

module mcs_cfg_regs (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [4:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output mcs_pkg::t_cfg       o_cfg
);

    mcs_pkg::t_cfg r_cfg;
    mcs_pkg::t_cfg n_cfg;
    logic          wr_en;
    logic [2:0]    idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[4:2];

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (idx)
                mcs_pkg::REG_DEADZONE:  n_cfg.deadzone  = pwdata[7:0];
                mcs_pkg::REG_SETTLE_MS: n_cfg.settle_ms = pwdata[7:0];
                mcs_pkg::REG_WDOG_MS:   n_cfg.wdog_ms   = pwdata[15:0];
                mcs_pkg::REG_LEFT_INV:  n_cfg.left_inv  = pwdata[0];
                mcs_pkg::REG_RIGHT_INV: n_cfg.right_inv = pwdata[0];
                mcs_pkg::REG_LEFT_ID:   n_cfg.left_id   = pwdata[7:0];
                mcs_pkg::REG_RIGHT_ID:  n_cfg.right_id  = pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.deadzone  <= mcs_pkg::RST_DEADZONE;
            r_cfg.settle_ms <= mcs_pkg::RST_SETTLE_MS;
            r_cfg.wdog_ms   <= mcs_pkg::RST_WDOG_MS;
            r_cfg.left_inv  <= mcs_pkg::RST_LEFT_INV;
            r_cfg.right_inv <= mcs_pkg::RST_RIGHT_INV;
            r_cfg.left_id   <= mcs_pkg::RST_LEFT_ID;
            r_cfg.right_id  <= mcs_pkg::RST_RIGHT_ID;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (idx)
            mcs_pkg::REG_DEADZONE:  prdata = {24'd0, r_cfg.deadzone};
            mcs_pkg::REG_SETTLE_MS: prdata = {24'd0, r_cfg.settle_ms};
            mcs_pkg::REG_WDOG_MS:   prdata = {16'd0, r_cfg.wdog_ms};
            mcs_pkg::REG_LEFT_INV:  prdata = {31'd0, r_cfg.left_inv};
            mcs_pkg::REG_RIGHT_INV: prdata = {31'd0, r_cfg.right_inv};
            mcs_pkg::REG_LEFT_ID:   prdata = {24'd0, r_cfg.left_id};
            mcs_pkg::REG_RIGHT_ID:  prdata = {24'd0, r_cfg.right_id};
            default:                prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- rtl/mcs_seq_core.sv -----
// Sequencer state and the single-pass logic that turns one transaction into
// up to four driver writes. Depends on mcs_pkg.
`default_nettype none

module mcs_seq_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_proc,
    input  wire logic           i_req_type,
    input  wire logic [8:0]     i_left_speed,
    input  wire logic [8:0]     i_right_speed,
    input  wire mcs_pkg::t_cfg  i_cfg,
    output mcs_pkg::t_batch     o_batch
);

    mcs_pkg::t_phase r_phase, n_phase;
    logic [8:0]      r_tgt_l, n_tgt_l, r_tgt_r, n_tgt_r;
    logic [8:0]      r_run_l, n_run_l, r_run_r, n_run_r;
    logic [7:0]      r_settle, n_settle;
    logic [16:0]     r_silence, n_silence;
    logic            r_armed, n_armed;

    logic        tick;
    logic [8:0]  lz, rz;
    logic        cmd_zero, rev, in_wait, settle_done, wd_fire;
    logic [7:0]  sc_inc;
    logic [16:0] sil_inc;

    logic        e_a, e_b;
    logic [15:0] a_addr, a_data, b_addr, b_data;
    mcs_pkg::t_wr w_a, w_b, w_c, w_d;

    assign tick = (i_req_type == mcs_pkg::REQ_TICK);
    assign lz   = (mcs_pkg::mag9(i_left_speed) < {1'b0, i_cfg.deadzone}) ? 9'd0 : i_left_speed;
    assign rz   = (mcs_pkg::mag9(i_right_speed) < {1'b0, i_cfg.deadzone}) ? 9'd0 : i_right_speed;
    assign cmd_zero = (lz == 9'd0) && (rz == 9'd0);
    assign rev = ((lz != 9'd0) && (r_run_l != 9'd0) && (lz[8] != r_run_l[8])) ||
                 ((rz != 9'd0) && (r_run_r != 9'd0) && (rz[8] != r_run_r[8]));
    assign in_wait     = (r_phase == mcs_pkg::PH_WAIT_DISABLE) ||
                         (r_phase == mcs_pkg::PH_WAIT_SPEED);
    assign sc_inc      = (r_settle == 8'hFF) ? r_settle : r_settle + 8'd1;
    assign settle_done = in_wait && (sc_inc >= i_cfg.settle_ms);
    assign sil_inc     = (r_silence == 17'h1FFFF) ? r_silence : r_silence + 17'd1;
    assign wd_fire     = tick && r_armed && (sil_inc > {1'b0, i_cfg.wdog_ms});

    // next state
    always_comb begin
        n_phase   = r_phase;
        n_tgt_l   = r_tgt_l;
        n_tgt_r   = r_tgt_r;
        n_run_l   = r_run_l;
        n_run_r   = r_run_r;
        n_settle  = r_settle;
        n_silence = r_silence;
        n_armed   = r_armed;
        if (!tick) begin
            n_silence = 17'd0;
            n_armed   = 1'b1;
            if (cmd_zero) begin
                n_tgt_l = 9'd0;
                n_tgt_r = 9'd0;
                n_run_l = 9'd0;
                n_run_r = 9'd0;
                n_phase = mcs_pkg::PH_IDLE;
            end else begin
                n_tgt_l  = lz;
                n_tgt_r  = rz;
                n_settle = 8'd0;
                n_phase  = rev ? mcs_pkg::PH_WAIT_DISABLE : mcs_pkg::PH_WAIT_SPEED;
            end
        end else begin
            n_silence = sil_inc;
            if (in_wait) begin
                n_settle = sc_inc;
            end
            if (settle_done) begin
                case (r_phase)
                    mcs_pkg::PH_WAIT_DISABLE: begin
                        n_settle = 8'd0;
                        n_phase  = mcs_pkg::PH_WAIT_SPEED;
                    end
                    mcs_pkg::PH_WAIT_SPEED: begin
                        n_run_l = r_tgt_l;
                        n_run_r = r_tgt_r;
                        n_phase = mcs_pkg::PH_IDLE;
                    end
                    default: ;
                endcase
            end
            if (wd_fire) begin
                n_tgt_l = 9'd0;
                n_tgt_r = 9'd0;
                n_run_l = 9'd0;
                n_run_r = 9'd0;
                n_phase = mcs_pkg::PH_IDLE;
                n_armed = 1'b0;
            end
        end
    end

    // write candidates: left, right, then the watchdog disable pair
    always_comb begin
        e_a    = 1'b0;
        e_b    = 1'b0;
        a_addr = mcs_pkg::ADDR_CONTROL;
        b_addr = mcs_pkg::ADDR_CONTROL;
        a_data = mcs_pkg::WORD_DISABLE;
        b_data = mcs_pkg::WORD_DISABLE;
        if (!tick) begin
            if (cmd_zero || rev) begin
                e_a = 1'b1;
                e_b = 1'b1;
            end else begin
                e_a    = (lz != 9'd0);
                e_b    = (rz != 9'd0);
                a_addr = mcs_pkg::ADDR_SPEED;
                b_addr = mcs_pkg::ADDR_SPEED;
                a_data = {7'd0, mcs_pkg::mag9(lz)};
                b_data = {7'd0, mcs_pkg::mag9(rz)};
            end
        end else if (settle_done) begin
            e_a = (r_tgt_l != 9'd0);
            e_b = (r_tgt_r != 9'd0);
            case (r_phase)
                mcs_pkg::PH_WAIT_DISABLE: begin
                    a_addr = mcs_pkg::ADDR_SPEED;
                    b_addr = mcs_pkg::ADDR_SPEED;
                    a_data = {7'd0, mcs_pkg::mag9(r_tgt_l)};
                    b_data = {7'd0, mcs_pkg::mag9(r_tgt_r)};
                end
                mcs_pkg::PH_WAIT_SPEED: begin
                    a_data = mcs_pkg::dir_word(r_tgt_l[8], i_cfg.left_inv);
                    b_data = mcs_pkg::dir_word(r_tgt_r[8], i_cfg.right_inv);
                end
                default: begin
                    e_a = 1'b0;
                    e_b = 1'b0;
                end
            endcase
        end
    end

    assign w_a = '{side: 1'b0, addr: a_addr, data: a_data};
    assign w_b = '{side: 1'b1, addr: b_addr, data: b_data};
    assign w_c = '{side: 1'b0, addr: mcs_pkg::ADDR_CONTROL, data: mcs_pkg::WORD_DISABLE};
    assign w_d = '{side: 1'b1, addr: mcs_pkg::ADDR_CONTROL, data: mcs_pkg::WORD_DISABLE};

    // pack enabled writes toward slot 0
    assign o_batch.slot[0] = e_a ? w_a : (e_b ? w_b : w_c);
    assign o_batch.slot[1] = (e_a && e_b) ? w_b : ((e_a || e_b) ? w_c : w_d);
    assign o_batch.slot[2] = (e_a && e_b) ? w_c : w_d;
    assign o_batch.slot[3] = w_d;
    assign o_batch.cnt     = {2'd0, e_a} + {2'd0, e_b} + {1'b0, wd_fire, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= mcs_pkg::PH_IDLE;
            r_tgt_l   <= 9'd0;
            r_tgt_r   <= 9'd0;
            r_run_l   <= 9'd0;
            r_run_r   <= 9'd0;
            r_settle  <= 8'd0;
            r_silence <= 17'd0;
            r_armed   <= 1'b1;
        end else if (i_proc) begin
            r_phase   <= n_phase;
            r_tgt_l   <= n_tgt_l;
            r_tgt_r   <= n_tgt_r;
            r_run_l   <= n_run_l;
            r_run_r   <= n_run_r;
            r_settle  <= n_settle;
            r_silence <= n_silence;
            r_armed   <= n_armed;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/mcs_result_buf.sv -----
// Result register: holds one transaction's writes and hands them out oldest
// first, one per cycle while popped. Depends on mcs_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module mcs_result_buf (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  wire mcs_pkg::t_batch i_batch,
    input  wire logic            i_pop,
    output logic                 o_can_load,
    output logic                 o_valid,
    output mcs_pkg::t_wr         o_wr,
    output logic                 o_last
);

    mcs_pkg::t_wr [mcs_pkg::MAX_WRITES-1:0] r_slot, n_slot;
    logic [2:0]                             r_cnt, n_cnt;
    logic                                   pop_ok;

    assign pop_ok     = i_pop && (r_cnt != 3'd0);
    assign o_can_load = (r_cnt == 3'd0) || ((r_cnt == 3'd1) && i_pop);
    assign o_valid    = (r_cnt != 3'd0);
    assign o_wr       = r_slot[0];
    assign o_last     = (r_cnt == 3'd1);

    always_comb begin
        n_slot = r_slot;
        n_cnt  = r_cnt;
        if (i_load) begin
            n_slot = i_batch.slot;
            n_cnt  = i_batch.cnt;
        end else if (pop_ok) begin
            for (int i = 0; i < mcs_pkg::MAX_WRITES - 1; i++) begin
                n_slot[i] = r_slot[i+1];
            end
            n_cnt = r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    `MCS_ASSERT(a_cnt_range, i_clk, i_rst_n, r_cnt <= 3'd4, "result count above four")
    `MCS_ASSERT(a_load_room, i_clk, i_rst_n, i_load |-> o_can_load, "load over pending writes")
    `MCS_ASSERT(a_drain, i_clk, i_rst_n, (pop_ok && !i_load) |=> (r_cnt == $past(r_cnt) - 3'd1), "pop did not drain one write")
    `MCS_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> (r_cnt == 3'd0), "buffer not empty after reset")

endmodule

`default_nettype wire

// ----- rtl/motor_command_sequencer_unit.sv -----
// Motor command sequencer. An input transaction is registered, evaluated in
// one pass against the sequencer state, and its driver writes (zero to four)
// land in a result register that drains one write per cycle while the output
// is not stalled. An item's writes are loaded only once the previous item's
// writes have drained or its last write is leaving, so the single output port
// sets the item rate. The next item is taken into the input register while the
// previous item's writes are still draining. Depends on mcs_pkg,
// mcs_cfg_regs, mcs_seq_core and mcs_result_buf.
`default_nettype none

module motor_command_sequencer_unit (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  wire logic         i_in_valid,
    output logic              o_in_stall,
    input  wire logic         i_req_type,
    input  wire logic [8:0]   i_left_speed,
    input  wire logic [8:0]   i_right_speed,
    output logic              o_out_valid,
    input  wire logic         i_out_stall,
    output logic              o_motor_side,
    output logic [7:0]        o_unit_id,
    output logic [15:0]       o_reg_addr,
    output logic [15:0]       o_reg_data,
    output logic              o_last_write
);

    mcs_pkg::t_cfg   cfg;
    mcs_pkg::t_batch batch;
    mcs_pkg::t_wr    out_wr;

    logic       r_in_valid;
    logic       r_in_type;
    logic [8:0] r_in_left, r_in_right;
    logic       can_load, proc, in_acc;

    assign proc       = r_in_valid && can_load;
    assign o_in_stall = r_in_valid && !can_load;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_type  <= i_req_type;
            r_in_left  <= i_left_speed;
            r_in_right <= i_right_speed;
        end
    end

    mcs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mcs_seq_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_proc        (proc),
        .i_req_type    (r_in_type),
        .i_left_speed  (r_in_left),
        .i_right_speed (r_in_right),
        .i_cfg         (cfg),
        .o_batch       (batch)
    );

    mcs_result_buf u_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (proc),
        .i_batch    (batch),
        .i_pop      (!i_out_stall),
        .o_can_load (can_load),
        .o_valid    (o_out_valid),
        .o_wr       (out_wr),
        .o_last     (o_last_write)
    );

    assign o_motor_side = out_wr.side;
    assign o_unit_id    = out_wr.side ? cfg.right_id : cfg.left_id;
    assign o_reg_addr   = out_wr.addr;
    assign o_reg_data   = out_wr.data;

endmodule

`default_nettype wire
